FILE: rtl/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants of the button debouncer with long press
// detection: register map, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  // counter width default
  localparam int COUNT_WIDTH_DEF = 16;

  // register map
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_DEBOUNCE_TICKS   = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS_TICKS = 2'd1;
  localparam logic [1:0] REG_ACTIVE_HIGH      = 2'd2;

  // register reset values
  localparam logic [15:0] DEBOUNCE_TICKS_RST   = 16'd50;
  localparam logic [15:0] LONG_PRESS_TICKS_RST = 16'd1000;
  localparam logic        ACTIVE_HIGH_RST      = 1'b1;

  // configuration bundle handed from the register block
  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] long_press_ticks;
    logic        active_high;
  } bdlp_cfg_t;

endpackage

FILE: rtl/bdlp_regs.sv
// ----------------------------------------------------------------------------
// bdlp_regs
// APB-style configuration registers: debounce wait, long press limit and
// active level. Always ready, writes in the access cycle.
// ----------------------------------------------------------------------------
module bdlp_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bdlp_pkg::ADDR_W-1:0] paddr,
  input  logic [bdlp_pkg::DATA_W-1:0] pwdata,
  output logic [bdlp_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output bdlp_pkg::bdlp_cfg_t        cfg
);
  import bdlp_pkg::*;

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= DEBOUNCE_TICKS_RST;
      cfg.long_press_ticks <= LONG_PRESS_TICKS_RST;
      cfg.active_high      <= ACTIVE_HIGH_RST;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_DEBOUNCE_TICKS:   cfg.debounce_ticks   <= pwdata[15:0];
        REG_LONG_PRESS_TICKS: cfg.long_press_ticks <= pwdata[15:0];
        REG_ACTIVE_HIGH:      cfg.active_high      <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_index)
      REG_DEBOUNCE_TICKS:   prdata = {16'd0, cfg.debounce_ticks};
      REG_LONG_PRESS_TICKS: prdata = {16'd0, cfg.long_press_ticks};
      REG_ACTIVE_HIGH:      prdata = {31'd0, cfg.active_high};
      default:              prdata = '0;
    endcase
  end

endmodule

FILE: rtl/button_debounce_long_press_core.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press_core
// Debouncer with press, release and long press events, one tick per item.
// ----------------------------------------------------------------------------
// Each accepted item is one millisecond tick with the raw pin level and a
// consume flag. The block takes one item every clock cycle unless the result
// register stalls, and returns its result item in the next cycle from that
// register; the rate is set by the state update (two saturating counters, two
// compares and the phase logic). An item is accepted only when the result
// register is free or its result is being taken in the same cycle. Counters are
// COUNT_WIDTH bits wide and saturate. The user writes configuration through
// the APB-style port only while no item is in flight; the block does not enforce it.
module button_debounce_long_press_core #(
  parameter int COUNT_WIDTH = bdlp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        pin_level,
  input  logic                        read_events,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        is_pressed,
  output logic                        is_long_pressed,
  output logic                        pressed_event,
  output logic                        released_event,
  output logic                        long_press_event,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bdlp_pkg::ADDR_W-1:0] paddr,
  input  logic [bdlp_pkg::DATA_W-1:0] pwdata,
  output logic [bdlp_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import bdlp_pkg::*;

  typedef enum logic [1:0] {
    PH_UNINIT = 2'd0,
    PH_IDLE   = 2'd1,
    PH_WAIT   = 2'd2
  } phase_t;

  bdlp_cfg_t cfg;

  phase_t                 phase, phase_next;
  logic                   stable_level, stable_level_next;
  logic [COUNT_WIDTH-1:0] debounce_count, debounce_count_next;
  logic [COUNT_WIDTH-1:0] hold_count, hold_count_next;
  logic                   press_latch, press_latch_next;
  logic                   release_latch, release_latch_next;
  logic                   long_reported, long_reported_next;

  logic [COUNT_WIDTH-1:0] debounce_inc, hold_inc;
  logic                   wait_done;
  logic                   pressed, longp, lpev;
  logic                   in_accept;

  // configuration registers
  bdlp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // accept while the result register is free or draining
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // saturating counters
  assign debounce_inc = (&debounce_count) ? debounce_count : debounce_count + 1'b1;
  assign hold_inc     = (&hold_count) ? hold_count : hold_count + 1'b1;
  assign wait_done    = {16'd0, debounce_inc} >= {{COUNT_WIDTH{1'b0}}, cfg.debounce_ticks};

  // per-tick update
  always_comb begin
    phase_next          = phase;
    stable_level_next   = stable_level;
    debounce_count_next = debounce_inc;
    hold_count_next     = hold_inc;
    press_latch_next    = press_latch;
    release_latch_next  = release_latch;
    long_reported_next  = long_reported;

    unique case (phase)
      PH_UNINIT: begin
        stable_level_next   = pin_level;
        hold_count_next     = '0;
        debounce_count_next = '0;
        phase_next          = PH_WAIT;
      end
      PH_WAIT: begin
        if (wait_done) begin
          if (pin_level != stable_level) begin
            stable_level_next = pin_level;
            hold_count_next   = '0;
            if (pin_level == cfg.active_high) begin
              press_latch_next   = 1'b1;
              long_reported_next = 1'b0;
            end else begin
              release_latch_next = 1'b1;
            end
          end
          phase_next = PH_IDLE;
        end
      end
      default: begin
        // idle, and the unused code behaves as idle
        if (pin_level != stable_level) begin
          debounce_count_next = '0;
          phase_next          = PH_WAIT;
        end
      end
    endcase

    pressed = (stable_level_next == cfg.active_high);
    longp   = pressed &&
              ({16'd0, hold_count_next} > {{COUNT_WIDTH{1'b0}}, cfg.long_press_ticks});
    lpev    = read_events && longp && !long_reported_next;
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_UNINIT;
      stable_level   <= 1'b0;
      debounce_count <= '0;
      hold_count     <= '0;
      press_latch    <= 1'b0;
      release_latch  <= 1'b0;
      long_reported  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      out_valid <= in_accept || (out_valid && !out_ready);
      if (in_accept) begin
        phase          <= phase_next;
        stable_level   <= stable_level_next;
        debounce_count <= debounce_count_next;
        hold_count     <= hold_count_next;
        press_latch    <= press_latch_next && !read_events;
        release_latch  <= release_latch_next && !read_events;
        long_reported  <= long_reported_next || lpev;
      end
    end
    // result payload
    if (in_accept) begin
      is_pressed       <= pressed;
      is_long_pressed  <= longp;
      pressed_event    <= press_latch_next;
      released_event   <= release_latch_next;
      long_press_event <= lpev;
    end
  end

endmodule

FILE: rtl/bdlp_checker.sv
// ----------------------------------------------------------------------------
// bdlp_checker
// Port-level checks of the debouncer core, attached by bind.
// ----------------------------------------------------------------------------
module bdlp_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic is_pressed,
  input logic is_long_pressed,
  input logic long_press_event
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result stays valid and keeps its status bits and long press event
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(is_pressed) &&
    $stable(is_long_pressed) && $stable(long_press_event))
    else $error("stalled result changed");

  // input is taken whenever the result register can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow result register");

  // long press implies pressed
  a_long: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_long_pressed |-> is_pressed)
    else $error("long press without press");

  // long press event only with long press
  a_lpev: assert property (@(posedge clk) disable iff (rst)
    out_valid && long_press_event |-> is_long_pressed)
    else $error("long press event without long press");

endmodule

bind button_debounce_long_press_core bdlp_checker u_bdlp_checker (
  .clk              (clk),
  .rst              (rst),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .is_pressed       (is_pressed),
  .is_long_pressed  (is_long_pressed),
  .long_press_event (long_press_event)
);

FILE: tb/button_debounce_long_press_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press_core_tb
// Self-checking bench for the button debouncer with long press detection.
// Ticks go in on the valid/ready input channel with random gaps. A
// scoreboard predicts every status item from its own model of the
// debounce phases, saturating counters and event latches, and checks each
// returned item in order. Runs cover the reset values, then settings changed
// through the APB port between phases: zero and small thresholds, both
// polarities and the 16-bit register extremes.
// ----------------------------------------------------------------------------
module button_debounce_long_press_core_tb;
  import bdlp_pkg::*;

  localparam int CW = COUNT_WIDTH_DEF;

  // directed ticks, first tick in the msb
  localparam logic [23:0] DIR_PIN  = 24'b111111010001111100011110;
  localparam logic [23:0] DIR_READ = 24'b000011000010000100101110;

  // debounce phases of the predictor
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_STEADY = 2'd1,
    PH_SETTLE = 2'd2
  } tick_phase_t;

  // one status item, in port order
  typedef struct packed {
    logic is_pressed;
    logic is_long_pressed;
    logic pressed_event;
    logic released_event;
    logic long_press_event;
  } btn_status_t;

  // predictor of the debouncer plus the store of predicted status items
  class debounce_scoreboard;
    bdlp_cfg_t     cfg;
    tick_phase_t   phase;
    logic          stable;
    logic [CW-1:0] settle_cnt;
    logic [CW-1:0] hold_cnt;
    logic          press_seen;
    logic          release_seen;
    logic          long_done;
    btn_status_t   status_q[$];
    int            mismatches;

    function new();
      cfg.debounce_ticks   = DEBOUNCE_TICKS_RST;
      cfg.long_press_ticks = LONG_PRESS_TICKS_RST;
      cfg.active_high      = ACTIVE_HIGH_RST;
      phase        = PH_FIRST;
      stable       = 1'b0;
      settle_cnt   = '0;
      hold_cnt     = '0;
      press_seen   = 1'b0;
      release_seen = 1'b0;
      long_done    = 1'b0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_DEBOUNCE_TICKS:   cfg.debounce_ticks = val[15:0];
        REG_LONG_PRESS_TICKS: cfg.long_press_ticks = val[15:0];
        REG_ACTIVE_HIGH:      cfg.active_high = val[0];
        default: ;
      endcase
    endfunction

    // advance one tick and queue the status it produces
    function void note_tick(logic pin, logic rd);
      btn_status_t st;
      if (settle_cnt != '1) settle_cnt = settle_cnt + 1'b1;
      if (hold_cnt != '1) hold_cnt = hold_cnt + 1'b1;
      case (phase)
        PH_FIRST: begin
          stable     = pin;
          hold_cnt   = '0;
          settle_cnt = '0;
          phase      = PH_SETTLE;
        end
        PH_SETTLE: begin
          if (settle_cnt >= cfg.debounce_ticks) begin
            if (pin != stable) begin
              stable   = pin;
              hold_cnt = '0;
              if (stable == cfg.active_high) begin
                press_seen = 1'b1;
                long_done  = 1'b0;
              end else begin
                release_seen = 1'b1;
              end
            end
            phase = PH_STEADY;
          end
        end
        // steady, and the unused code behaves the same
        default: begin
          if (pin != stable) begin
            settle_cnt = '0;
            phase      = PH_SETTLE;
          end
        end
      endcase
      st.is_pressed       = (stable == cfg.active_high);
      st.is_long_pressed  = st.is_pressed && (hold_cnt > cfg.long_press_ticks);
      st.pressed_event    = press_seen;
      st.released_event   = release_seen;
      st.long_press_event = rd && st.is_long_pressed && !long_done;
      status_q.push_back(st);
      // consuming clears the latches after they are reported
      if (rd) begin
        press_seen   = 1'b0;
        release_seen = 1'b0;
        if (st.long_press_event) long_done = 1'b1;
      end
    endfunction

    function void flag(string what, btn_status_t exp, btn_status_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: exp pr=%b lp=%b pe=%b re=%b le=%b got pr=%b lp=%b pe=%b re=%b le=%b",
                 $time, what, exp.is_pressed, exp.is_long_pressed, exp.pressed_event,
                 exp.released_event, exp.long_press_event, got.is_pressed,
                 got.is_long_pressed, got.pressed_event, got.released_event,
                 got.long_press_event);
    endfunction

    function void check_result(btn_status_t got);
      btn_status_t exp;
      if (status_q.size() == 0) begin
        flag("status item with no tick pending", '0, got);
      end else begin
        exp = status_q.pop_front();
        if (got !== exp) flag("status mismatch", exp, got);
      end
    endfunction
  endclass

  // block ports
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        pin_level = 1'b0;
  logic        read_events = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        is_pressed;
  logic        is_long_pressed;
  logic        pressed_event;
  logic        released_event;
  logic        long_press_event;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic        pready;

  debounce_scoreboard sb;
  bit calm = 1'b0;
  int cur_db = int'(DEBOUNCE_TICKS_RST);
  int cur_lp = int'(LONG_PRESS_TICKS_RST);

  button_debounce_long_press_core uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .pin_level        (pin_level),
    .read_events      (read_events),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .is_pressed       (is_pressed),
    .is_long_pressed  (is_long_pressed),
    .pressed_event    (pressed_event),
    .released_event   (released_event),
    .long_press_event (long_press_event),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit idle_roll();
    return !calm && ($urandom_range(0, 99) < 12);
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= !idle_roll();
  end

  // watch both channels
  always @(posedge clk) begin : monitor
    btn_status_t got;
    if (!rst) begin
      if (in_valid && in_ready) sb.note_tick(pin_level, read_events);
      if (out_valid && out_ready) begin
        got = {is_pressed, is_long_pressed, pressed_event, released_event,
               long_press_event};
        sb.check_result(got);
      end
    end
  end

  // one tick, after a random gap
  task automatic send_item(input logic pin, input logic rd);
    int gap;
    gap = 0;
    while (idle_roll()) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pin_level   <= pin;
    read_events <= rd;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic hold_level(input logic lvl, input int n, input int rd_pct);
    for (int i = 0; i < n; i++) send_item(lvl, $urandom_range(0, 99) < rd_pct);
  endtask

  // stop sending and let every pending status item come back
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
  endtask

  task automatic apply_settings(input int db, input int lp, input logic ah);
    wait_for_quiet();
    apb_write(REG_DEBOUNCE_TICKS, db);
    apb_write(REG_LONG_PRESS_TICKS, lp);
    apb_write(REG_ACTIVE_HIGH, {31'd0, ah});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_db = db;
    cur_lp = lp;
  endtask

  // mostly settled holds with random reads, some glitches and noise
  task automatic random_run(input int count);
    int sent, kind, len, upper;
    logic lvl;
    sent = 0;
    while (sent < count) begin
      kind  = $urandom_range(0, 99);
      lvl   = 1'($urandom_range(0, 1));
      upper = cur_db + cur_lp + 6;
      if (upper > 300) upper = 300;
      if (kind < 70) begin
        len = $urandom_range(cur_db + 1, upper);
        hold_level(lvl, len, 20);
      end else if (kind < 85) begin
        len = $urandom_range(1, cur_db + 1);
        hold_level(lvl, len, 20);
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      sent += len;
    end
  endtask

  // time limit
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // stimulus
  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values, starting with the first tick
    random_run(200);
    hold_level(1'b0, 60, 0);
    send_item(1'b0, 1'b1);

    // directed: press, long press once, glitch, release, consume cases
    apply_settings(0, 1, 1'b1);
    for (int i = 23; i >= 0; i--) send_item(DIR_PIN[i], DIR_READ[i]);

    apply_settings(0, 0, 1'b1);
    random_run(200);
    apply_settings(3, 5, 1'b0);
    random_run(200);

    // a stretch with no idling on either side
    calm = 1'b1;
    apply_settings(1, 2, 1'b1);
    random_run(200);
    calm = 1'b0;

    repeat (3) begin
      apply_settings($urandom_range(0, 6), $urandom_range(0, 12), 1'($urandom_range(0, 1)));
      random_run(100);
    end

    // limit just under the counter maximum, active low
    apply_settings(0, 65534, 1'b0);
    hold_level(1'b0, 40, 3);
    // longest debounce wait, and a limit the counter never exceeds
    apply_settings(65535, 65535, 1'b1);
    hold_level(1'b1, 40, 3);

    apply_settings(2, 4, 1'b1);
    random_run(100);

    wait_for_quiet();
    if (sb.mismatches == 0 && sb.status_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: button_debounce_long_press_core.f
rtl/bdlp_pkg.sv
rtl/bdlp_regs.sv
rtl/button_debounce_long_press_core.sv
rtl/bdlp_checker.sv
tb/button_debounce_long_press_core_tb.sv
